// ----- sv/gbi_pkg.sv -----
package gbi_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int MAX_SPAN = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int IDX_W  = $clog2(MAX_SPAN);
    localparam int SPAN_W = $clog2(MAX_SPAN + 1);

    localparam int VAL_W     = 32;
    localparam int COORD_W   = 32;
    localparam int USED_W    = 7;
    localparam int FRAC_BITS = 16;
    localparam int FRAC_W    = FRAC_BITS + 1;
    localparam int POS_W     = COORD_W + COORD_W - FRAC_BITS;
    localparam int BLEND_W   = VAL_W + FRAC_BITS;

    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_BITS;

    localparam int RA_W       = ROW_W - 1;
    localparam int CA_W       = COL_W - 1;
    localparam int BANK_AW    = RA_W + CA_W;
    localparam int BANK_DEPTH = 1 << BANK_AW;
    localparam int NUM_BANKS  = 4;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_ORIGIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_INV_STEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_USED    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COL_ORIGIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COL_INV_STEP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_USED    = 3'd5;

    typedef struct packed {
        logic              ok;
        logic [IDX_W-1:0]  idx;
        logic [FRAC_W-1:0] frac;
    } axis_res_t;

    // Limit a configured node count to [2, max_n].
    function automatic logic [SPAN_W-1:0] clamp_used(input logic [USED_W-1:0] used,
                                                      input int unsigned max_n);
        int unsigned u;
        u = {25'd0, used};
        if (u < 2)
            return SPAN_W'(2);
        else if (u > max_n)
            return SPAN_W'(max_n);
        else
            return SPAN_W'(u);
    endfunction

endpackage

// ----- sv/gbi_bank.sv -----
module gbi_bank
    import gbi_pkg::*;
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [BANK_AW-1:0] wr_addr,
    input  logic [VAL_W-1:0]   wr_data,
    input  logic               rd_en,
    input  logic [BANK_AW-1:0] rd_addr,
    output logic [VAL_W-1:0]   rd_data
);

    logic [VAL_W-1:0] mem [BANK_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold read data while the stage downstream is stalled.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- sv/gbi_axis.sv -----
module gbi_axis
    import gbi_pkg::*;
(
    input  logic               clk,
    input  logic               en_diff,
    input  logic               en_pos,
    input  logic [COORD_W-1:0] coord,
    input  logic [COORD_W-1:0] origin,
    input  logic [COORD_W-1:0] inv_step,
    input  logic [SPAN_W-1:0]  used,
    output axis_res_t          res
);

    logic [COORD_W:0]           diff_reg;
    logic                       neg_reg;
    logic [POS_W-1:0]           pos_reg;
    logic [2*COORD_W-1:0]       prod;
    logic [SPAN_W-1:0]          last;
    logic [POS_W-FRAC_BITS-1:0] pos_int;
    logic                       over;
    logic                       at_last;

    always_ff @(posedge clk)
    begin
        if (en_diff)
        begin
            diff_reg <= {coord[COORD_W-1], coord} - {origin[COORD_W-1], origin};
        end
    end

    assign prod = diff_reg[COORD_W-1:0] * inv_step;

    always_ff @(posedge clk)
    begin
        if (en_pos)
        begin
            neg_reg <= diff_reg[COORD_W];
            pos_reg <= prod[2*COORD_W-1:FRAC_BITS];
        end
    end

    assign last    = used - SPAN_W'(1);
    assign pos_int = pos_reg[POS_W-1:FRAC_BITS];
    assign over    = pos_reg > (POS_W'(last) << FRAC_BITS);
    // Only a position exactly on the last node reaches it while in range.
    assign at_last = pos_int == (POS_W - FRAC_BITS)'(last);

    always_comb
    begin
        res.ok = !neg_reg && !over;
        if (at_last)
        begin
            res.idx  = IDX_W'(last - SPAN_W'(1));
            res.frac = FRAC_ONE;
        end
        else
        begin
            res.idx  = pos_reg[FRAC_BITS+IDX_W-1:FRAC_BITS];
            res.frac = {1'b0, pos_reg[FRAC_BITS-1:0]};
        end
    end

endmodule

// ----- sv/grid_bilinear_interpolation.sv -----
// Grid bilinear interpolation. Write items (cmd = write) fill a 64 x 64 grid of
// unsigned Q16.16 values; query items map a signed Q16.16 row/column coordinate
// through the configured origin and reciprocal step, pick the enclosing cell
// (clamped to the second-to-last node) and blend its four corners. A query
// outside the grid returns 1 with out_of_range set, and a blend of zero is
// raised to 1. Every query gives exactly one result item, a write gives none.
// The block takes one item per cycle while out_ready stays high. The grid sits
// in four banks split by row and column parity, each with one write and one
// read port, so the four corners of a cell come out in the same cycle. Writes
// travel down the same pipe as queries and update the bank in the stage where
// queries read, so every query sees exactly the writes accepted before it. The
// grid is not cleared at reset; a query must only touch entries already
// written. Configuration is taken on any cycle cfg_wr_en is high and should
// only change while the pipe is empty.
module grid_bilinear_interpolation
    import gbi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [31:0]          cfg_wr_data,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 cmd,
    input  logic [ROW_W-1:0]     wr_row,
    input  logic [COL_W-1:0]     wr_col,
    input  logic [VAL_W-1:0]     wr_value,
    input  logic [COORD_W-1:0]   row_coord,
    input  logic [COORD_W-1:0]   col_coord,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [VAL_W-1:0]     interp_value,
    output logic                 out_of_range
);

    // Configuration registers
    logic [COORD_W-1:0] row_origin_reg;
    logic [COORD_W-1:0] row_inv_step_reg;
    logic [USED_W-1:0]  rows_used_reg;
    logic [COORD_W-1:0] col_origin_reg;
    logic [COORD_W-1:0] col_inv_step_reg;
    logic [USED_W-1:0]  cols_used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_origin_reg   <= '0;
            row_inv_step_reg <= COORD_W'(65536);
            rows_used_reg    <= USED_W'(64);
            col_origin_reg   <= '0;
            col_inv_step_reg <= COORD_W'(65536);
            cols_used_reg    <= USED_W'(64);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx)
                REG_ROW_ORIGIN:   row_origin_reg   <= cfg_wr_data;
                REG_ROW_INV_STEP: row_inv_step_reg <= cfg_wr_data;
                REG_ROWS_USED:    rows_used_reg    <= cfg_wr_data[USED_W-1:0];
                REG_COL_ORIGIN:   col_origin_reg   <= cfg_wr_data;
                REG_COL_INV_STEP: col_inv_step_reg <= cfg_wr_data;
                REG_COLS_USED:    cols_used_reg    <= cfg_wr_data[USED_W-1:0];
                default:          ; // drop writes to unknown indexes
            endcase
        end
    end

    // Pipeline control: each stage loads when empty or when it drains.
    // Stage 1 holds coordinate differences, stage 2 the scaled positions,
    // stage 3 the bank read data, stage 4 the row blends, then the output.
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic en1, en2, en3, en4, en5;

    assign en5 = !out_valid_reg || out_ready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign in_ready  = en1;
    assign out_valid = out_valid_reg;

    // Write payload follows the query stages so the bank update lands in order.
    logic               cmd1_reg, cmd2_reg;
    logic [ROW_W-1:0]   wr_row1_reg, wr_row2_reg;
    logic [COL_W-1:0]   wr_col1_reg, wr_col2_reg;
    logic [VAL_W-1:0]   wr_value1_reg, wr_value2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
            // Write items end in stage 2; only queries go on.
            if (en3)
                v3_reg <= v2_reg && (cmd2_reg == CMD_QUERY);
            if (en4)
                v4_reg <= v3_reg;
            if (en5)
                out_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            cmd1_reg      <= cmd;
            wr_row1_reg   <= wr_row;
            wr_col1_reg   <= wr_col;
            wr_value1_reg <= wr_value;
        end
        if (en2)
        begin
            cmd2_reg      <= cmd1_reg;
            wr_row2_reg   <= wr_row1_reg;
            wr_col2_reg   <= wr_col1_reg;
            wr_value2_reg <= wr_value1_reg;
        end
    end

    // Axis scaling
    axis_res_t row_res, col_res;

    gbi_axis u_row_axis (
        .clk      (clk),
        .en_diff  (en1),
        .en_pos   (en2),
        .coord    (row_coord),
        .origin   (row_origin_reg),
        .inv_step (row_inv_step_reg),
        .used     (clamp_used(rows_used_reg, MAX_ROWS)),
        .res      (row_res)
    );

    gbi_axis u_col_axis (
        .clk      (clk),
        .en_diff  (en1),
        .en_pos   (en2),
        .coord    (col_coord),
        .origin   (col_origin_reg),
        .inv_step (col_inv_step_reg),
        .used     (clamp_used(cols_used_reg, MAX_COLS)),
        .res      (col_res)
    );

    // Bank addressing. Bank {pr, pc} holds rows of parity pr and columns of
    // parity pc; of rows ri and ri+1 exactly one has each parity.
    logic [ROW_W-1:0] ri, ri_inc;
    logic [COL_W-1:0] ci, ci_inc;
    logic             do_write, do_read;
    logic [1:0]       wr_bank;
    logic [BANK_AW-1:0] wr_addr;
    logic [BANK_AW-1:0] rd_addr [NUM_BANKS];
    logic [VAL_W-1:0]   rd_data [NUM_BANKS];

    assign ri     = row_res.idx[ROW_W-1:0];
    assign ci     = col_res.idx[COL_W-1:0];
    assign ri_inc = ri + ROW_W'(1);
    assign ci_inc = ci + COL_W'(1);

    assign do_write = en3 && v2_reg && (cmd2_reg == CMD_WRITE);
    assign do_read  = en3 && v2_reg && (cmd2_reg == CMD_QUERY);
    assign wr_bank  = {wr_row2_reg[0], wr_col2_reg[0]};
    assign wr_addr  = {wr_row2_reg[ROW_W-1:1], wr_col2_reg[COL_W-1:1]};

    for (genvar b = 0; b < NUM_BANKS; b++)
    begin : g_bank
        localparam logic [1:0] BANK_ID = 2'(b);
        localparam logic PR = BANK_ID[1];
        localparam logic PC = BANK_ID[0];
        logic [ROW_W-1:0] row_sel;
        logic [COL_W-1:0] col_sel;

        assign row_sel    = (ri[0] == PR) ? ri : ri_inc;
        assign col_sel    = (ci[0] == PC) ? ci : ci_inc;
        assign rd_addr[b] = {row_sel[ROW_W-1:1], col_sel[COL_W-1:1]};

        gbi_bank u_bank (
            .clk     (clk),
            .wr_en   (do_write && (wr_bank == BANK_ID)),
            .wr_addr (wr_addr),
            .wr_data (wr_value2_reg),
            .rd_en   (do_read),
            .rd_addr (rd_addr[b]),
            .rd_data (rd_data[b])
        );
    end

    // Stage 3: corners out of the banks, blend along rows
    logic              ok3_reg, rpar3_reg, cpar3_reg;
    logic [FRAC_W-1:0] fr3_reg, fc3_reg;

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            ok3_reg   <= row_res.ok && col_res.ok;
            fr3_reg   <= row_res.frac;
            fc3_reg   <= col_res.frac;
            rpar3_reg <= ri[0];
            cpar3_reg <= ci[0];
        end
    end

    logic [VAL_W-1:0]        v00, v10, v01, v11;
    logic [FRAC_W-1:0]       wr_lo;
    logic [VAL_W+FRAC_W-1:0] p00, p10, p01, p11;
    logic [VAL_W+FRAC_W-1:0] sum0, sum1;

    assign v00   = rd_data[{rpar3_reg, cpar3_reg}];
    assign v10   = rd_data[{~rpar3_reg, cpar3_reg}];
    assign v01   = rd_data[{rpar3_reg, ~cpar3_reg}];
    assign v11   = rd_data[{~rpar3_reg, ~cpar3_reg}];
    assign wr_lo = FRAC_ONE - fr3_reg;
    assign p00   = v00 * wr_lo;
    assign p10   = v10 * fr3_reg;
    assign p01   = v01 * wr_lo;
    assign p11   = v11 * fr3_reg;
    // Convex blend: each sum stays below 2^48.
    assign sum0  = p00 + p10;
    assign sum1  = p01 + p11;

    // Stage 4: blend along columns
    logic               ok4_reg;
    logic [FRAC_W-1:0]  fc4_reg;
    logic [BLEND_W-1:0] b0_reg, b1_reg;

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            ok4_reg <= ok3_reg;
            fc4_reg <= fc3_reg;
            b0_reg  <= sum0[BLEND_W-1:0];
            b1_reg  <= sum1[BLEND_W-1:0];
        end
    end

    logic [FRAC_W-1:0]         wc_lo;
    logic [BLEND_W+FRAC_W-1:0] q0, q1, qsum;
    logic [VAL_W-1:0]          blend;

    assign wc_lo = FRAC_ONE - fc4_reg;
    assign q0    = b0_reg * wc_lo;
    assign q1    = b1_reg * fc4_reg;
    assign qsum  = q0 + q1;
    assign blend = qsum[2*VAL_W-1:VAL_W];

    // Output register: floor at one LSB, force the floor when off the grid
    logic [VAL_W-1:0] interp_value_reg;
    logic             out_of_range_reg;

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            out_of_range_reg <= !ok4_reg;
            if (!ok4_reg || (blend == '0))
                interp_value_reg <= VAL_W'(1);
            else
                interp_value_reg <= blend;
        end
    end

    assign interp_value = interp_value_reg;
    assign out_of_range = out_of_range_reg;

endmodule
